/* rtl/deq_pkg.sv */
`timescale 1ns / 1ps

package deq_pkg;

    // Ring geometry.
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Capacity register.
    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Command codes.
    localparam logic [1:0] CMD_PUSH_REAR  = 2'd0;
    localparam logic [1:0] CMD_POP_FRONT  = 2'd1;
    localparam logic [1:0] CMD_PUSH_FRONT = 2'd2;
    localparam logic [1:0] CMD_POP_REAR   = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] push_value;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [1:0]         status;
        logic [4:0]         fill_count;
    } result_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;  // capture the incoming command beat
        logic exec;  // carry out the captured command
    } ctrl_t;

endpackage

/* rtl/deq_ctrl.sv */
`timescale 1ns / 1ps

module deq_ctrl
    import deq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    output logic  result_valid,
    output ctrl_t ctrl
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic strobe_reg;
    logic strobe_next;

    always_comb
    begin
        state_next  = state_reg;
        strobe_next = 1'b0;
        ctrl.load   = 1'b0;
        ctrl.exec   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctrl.exec   = 1'b1;
                strobe_next = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    assign busy         = (state_reg == S_EXEC);
    assign result_valid = strobe_reg;

endmodule

/* rtl/deq_dpath.sv */
`timescale 1ns / 1ps

module deq_dpath
    import deq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  ctrl_t            ctrl,
    input  cmd_t             cmd,
    input  logic             cfg_wr,
    input  logic [CAP_W-1:0] cfg_data,
    output result_t          result
);

    logic [31:0]      mem [DEPTH];
    cmd_t             cmd_reg;
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CAP_W-1:0] cap_reg;
    logic [31:0]      rd_data_reg;
    logic [1:0]       status_reg;
    logic [1:0]       status_next;
    logic             pop_ok_reg;
    logic             push_ok_reg;

    logic [CNT_W-1:0] eff_cap;
    logic             full;
    logic             empty;
    logic             is_push;
    logic             ok;
    logic [IDX_W-1:0] addr;

    // Head plus an offset of at most DEPTH, wrapped once around the ring.
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] head,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(head) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(DEPTH))
            sum = sum - (CNT_W+1)'(DEPTH);
        return sum[IDX_W-1:0];
    endfunction

    always_comb
    begin
        eff_cap = ((CAP_W+1)'(cap_reg) > (CAP_W+1)'(DEPTH)) ? CNT_W'(DEPTH)
                                                            : CNT_W'(cap_reg);
        full    = (count_reg >= eff_cap);
        empty   = (count_reg == '0);
        is_push = cmd_reg.command inside {CMD_PUSH_REAR, CMD_PUSH_FRONT};
        ok      = is_push ? !full : !empty;

        head_next   = head_reg;
        count_next  = count_reg;
        status_next = ST_OK;
        addr        = head_reg;
        case (cmd_reg.command)
            CMD_PUSH_REAR:
            begin
                addr = ring_add(head_reg, count_reg);
            end
            CMD_POP_FRONT:
            begin
                addr = head_reg;
                if (ok)
                    head_next = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
            end
            CMD_PUSH_FRONT:
            begin
                addr = (head_reg == '0) ? IDX_W'(DEPTH - 1) : head_reg - 1'b1;
                if (ok)
                    head_next = addr;
            end
            default:
            begin
                addr = ring_add(head_reg, count_reg - 1'b1);
            end
        endcase

        if (!ok)
            status_next = is_push ? ST_FULL : ST_EMPTY;
        else if (is_push)
            count_next = count_reg + 1'b1;
        else
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            count_reg   <= '0;
            cap_reg     <= CAP_RESET;
            pop_ok_reg  <= 1'b0;
            push_ok_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
                cap_reg <= cfg_data;
            if (ctrl.exec)
            begin
                head_reg    <= head_next;
                count_reg   <= count_next;
                pop_ok_reg  <= ok && !is_push;
                push_ok_reg <= ok && is_push;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
            cmd_reg <= cmd;
        if (ctrl.exec)
        begin
            status_reg  <= status_next;
            rd_data_reg <= mem[addr];
            if (is_push && ok)
                mem[addr] <= cmd_reg.push_value;
        end
    end

    always_comb
    begin
        if (pop_ok_reg)
            result.result_value = rd_data_reg;
        else if (push_ok_reg)
            result.result_value = cmd_reg.push_value;
        else
            result.result_value = '0;
        result.status     = status_reg;
        result.fill_count = 5'(count_reg);
    end

endmodule

/* rtl/double_ended_queue.sv */
`timescale 1ns / 1ps

// Circular double-ended queue of signed 32-bit words held in a 16-entry ring.
// A command beat is taken when start is high and busy is low; each beat pushes
// at the rear or front, or pops from the front or rear. Exactly one result beat
// follows, appearing as busy drops, marked by result_valid for a single
// cycle. The receiver cannot stall, so the result must be captured on that
// cycle. A command first captures the beat, then writes or reads the ring
// memory through its registered read port. Because busy is already low during
// the result cycle, a new command may be issued while the previous result is
// on the ports. A push echoes its word and a pop returns the removed word; a
// refused command (full on push, empty on pop) returns zero and leaves the
// queue unchanged. fill_count always gives the number of entries held after
// the command. The capacity register (reset 16, values above 16 act as 16,
// zero makes every push report full) is written through the cfg channel, which
// is always ready; write it only while no command is outstanding. A pop only
// returns entries that were written, so the ring needs no clearing after reset.

module double_ended_queue
    import deq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cmd_t             cmd,
    output logic             result_valid,
    output result_t          result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data
);

    ctrl_t ctrl;

    // Configuration writes are always accepted.
    assign cfg_ready = 1'b1;

    deq_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .result_valid (result_valid),
        .ctrl         (ctrl)
    );

    deq_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .cmd      (cmd),
        .cfg_wr   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .result   (result)
    );

endmodule

/* rtl/deq_checker.sv */
`timescale 1ns / 1ps

module deq_checker
    import deq_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input cmd_t             cmd,
    input logic             result_valid,
    input result_t          result,
    input logic             cfg_valid,
    input logic             cfg_ready,
    input logic [CAP_W-1:0] cfg_data
);

    // An accepted command keeps the block busy for the following cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // Each busy cycle is followed by a result beat with busy low.
    a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (result_valid && !busy))
        else $error("busy cycle not followed by a result beat");

    // A result beat only appears after a busy cycle.
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(busy))
        else $error("result beat without a command");

    // The fill count never exceeds the ring depth.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.fill_count <= 5'(DEPTH)))
        else $error("fill count beyond depth");

    // A refused command returns zero.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status != ST_OK)) |-> (result.result_value == '0))
        else $error("refused command returned a nonzero word");

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);
